// ===== hw/rtl/smx_pkg.sv =====
package smx_pkg;

  localparam int WORD_WIDTH_DEF       = 32;
  localparam int DATA_STACK_DEPTH_DEF = 256;
  localparam int CALL_STACK_DEPTH_DEF = 256;
  localparam int MEMORY_DEPTH_DEF     = 256;
  localparam int PROGRAM_DEPTH_DEF    = 1024;

  localparam int OPCODE_W = 5;
  localparam int ARG_W    = 32;
  localparam int IP_W     = 10;
  localparam int PRINT_W  = 32;
  localparam int ERR_W    = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 5'd0,  OP_POP = 5'd1,  OP_DUP = 5'd2,  OP_ADD = 5'd3,
    OP_SUB  = 5'd4,  OP_MUL = 5'd5,  OP_DIV = 5'd6,  OP_JMP = 5'd7,
    OP_JIT  = 5'd8,  OP_JIF = 5'd9,  OP_CALL = 5'd10, OP_RET = 5'd11,
    OP_STL  = 5'd12, OP_RCE = 5'd13, OP_EQ = 5'd14,  OP_GT = 5'd15,
    OP_GE   = 5'd16, OP_LT = 5'd17,  OP_LE = 5'd18,  OP_NE = 5'd19,
    OP_STO  = 5'd20, OP_RCL = 5'd21, OP_END = 5'd22, OP_PRN = 5'd23,
    OP_FRE  = 5'd24, OP_ALC = 5'd25
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 3'd0,
    ERR_OVER    = 3'd1,
    ERR_UNDER   = 3'd2,
    ERR_CALL    = 3'd3,
    ERR_DIVZERO = 3'd4,
    ERR_ADDR    = 3'd5
  } err_t;

  // operand classes found by the front end
  typedef struct packed {
    logic [1:0] pops;      // data stack entries read
    logic       binop;
    logic       is_div;
  } op_class_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_RD, EX_WAIT, EX_DIV, EX_DONE
  } ex_state_t;

  function automatic op_class_t classify(input logic [OPCODE_W-1:0] op);
    op_class_t c;
    c = '0;
    unique case (op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
      OP_NE: begin
        c.pops  = 2'd2;
        c.binop = 1'b1;
        c.is_div = (op == OP_DIV);
      end
      OP_POP, OP_DUP, OP_JIT, OP_JIF, OP_STL, OP_STO, OP_PRN: c.pops = 2'd1;
      default: c.pops = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/smx_ram.sv =====
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/smx_div.sv =====
// signed restoring divider, one quotient bit per cycle, truncating
module smx_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [W:0]    rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [W:0]    trial;

  assign trial = {rem[W-1:0], q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= dividend[W-1] ? W'(-dividend) : dividend;
        d    <= divisor[W-1] ? W'(-divisor) : divisor;
        rem  <= '0;
        neg  <= dividend[W-1] ^ divisor[W-1];
      end else if (busy) begin
        if (trial[W]) begin
          rem <= {rem[W-1:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end else begin
          rem <= trial;
          q   <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? W'(-q) : q;
endmodule

// ===== hw/rtl/smx_front.sv =====
// input skid: holds one decoded item for the execute stage
module smx_front import smx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic                new_run,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [ARG_W-1:0]    argument,
  output logic                q_valid,
  input  logic                q_take,
  output logic                q_new_run,
  output logic [OPCODE_W-1:0] q_opcode,
  output logic [ARG_W-1:0]    q_argument,
  output op_class_t           q_class
);
  assign ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (valid && ready) begin
      q_valid <= 1'b1;
    end else if (q_take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      q_new_run  <= new_run;
      q_opcode   <= opcode;
      q_argument <= argument;
      q_class    <= classify(opcode);
    end
  end

`ifndef SYNTHESIS
  a_take_valid: assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("take from empty queue");
`endif
endmodule

// ===== hw/rtl/smx_exec.sv =====
module smx_exec import smx_pkg::*; #(
  parameter int WORD_WIDTH       = WORD_WIDTH_DEF,
  parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
  parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
  parameter int MEMORY_DEPTH     = MEMORY_DEPTH_DEF,
  parameter int PROGRAM_DEPTH    = PROGRAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  logic                q_new_run,
  input  logic [OPCODE_W-1:0] q_opcode,
  input  logic [ARG_W-1:0]    q_argument,
  input  op_class_t           q_class,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IP_W-1:0]     next_ip,
  output logic                print_valid,
  output logic [PRINT_W-1:0]  print_value,
  output logic                halted,
  output logic [ERR_W-1:0]    error_code
);
  localparam int W   = WORD_WIDTH;
  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DTW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int CAW = $clog2(CALL_STACK_DEPTH);
  localparam int CTW = $clog2(CALL_STACK_DEPTH + 1);
  localparam int MAW = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
  localparam int PAW = $clog2(PROGRAM_DEPTH);
  localparam int XW  = 34;  // signed working width for index checks

  ex_state_t state, state_next;

  logic [PAW-1:0] ip;
  logic [DTW-1:0] dtop;
  logic [CTW-1:0] ctop;
  logic [CAW-1:0] fb;

  // memories
  logic           ds_we, cs_we, dm_we;
  logic [DAW-1:0] ds_waddr, ds_ra, ds_rb;
  logic [W-1:0]   ds_wdata, ds_qa, ds_qb;
  logic [CAW-1:0] cs_waddr, cs_ra, cs_rb;
  logic [W-1:0]   cs_wdata, cs_qa, cs_qb;
  logic [MAW-1:0] dm_waddr, dm_raddr;
  logic [W-1:0]   dm_wdata, dm_q;
  logic           cs_we2;
  logic [CAW-1:0] cs_waddr2;
  logic [W-1:0]   cs_wdata2;

  // ports a/b of the stacks are two copies written together
  smx_ram #(.WIDTH(W), .DEPTH(DATA_STACK_DEPTH)) u_dsa (.clk, .we(ds_we),
    .waddr(ds_waddr), .wdata(ds_wdata), .raddr(ds_ra), .rdata(ds_qa));
  smx_ram #(.WIDTH(W), .DEPTH(DATA_STACK_DEPTH)) u_dsb (.clk, .we(ds_we),
    .waddr(ds_waddr), .wdata(ds_wdata), .raddr(ds_rb), .rdata(ds_qb));
  smx_ram #(.WIDTH(W), .DEPTH(CALL_STACK_DEPTH)) u_csa (.clk, .we(cs_we),
    .waddr(cs_waddr), .wdata(cs_wdata), .raddr(cs_ra), .rdata(cs_qa));
  smx_ram #(.WIDTH(W), .DEPTH(CALL_STACK_DEPTH)) u_csb (.clk, .we(cs_we),
    .waddr(cs_waddr), .wdata(cs_wdata), .raddr(cs_rb), .rdata(cs_qb));
  smx_ram #(.WIDTH(W), .DEPTH(MEMORY_DEPTH)) u_dm (.clk, .we(dm_we),
    .waddr(dm_waddr), .wdata(dm_wdata), .raddr(dm_raddr), .rdata(dm_q));

  // operand decode
  logic signed [XW-1:0] args, lidx, alc_t;
  logic [CAW-1:0] fb_eff;
  logic           tgt_bad, mem_bad, loc_bad, alc_bad;
  opcode_t        op;

  assign op      = opcode_t'(q_opcode);
  assign fb_eff  = q_new_run ? '0 : fb;
  assign args    = XW'(signed'(q_argument));
  assign tgt_bad = args < 0 || args >= XW'(PROGRAM_DEPTH);
  assign mem_bad = args < 0 || args >= XW'(MEMORY_DEPTH);
  assign lidx    = XW'({1'b0, fb_eff}) + args + XW'(1);
  assign loc_bad = lidx < 0 || lidx >= XW'(CALL_STACK_DEPTH);
  assign alc_t   = (op == OP_ALC) ? XW'({1'b0, ctop}) + args : XW'({1'b0, ctop}) - args;
  assign alc_bad = alc_t < 0 || alc_t > XW'(CALL_STACK_DEPTH);

  assign ds_ra = DAW'(dtop - DTW'(1));
  assign ds_rb = DAW'(dtop - DTW'(2));
  assign cs_ra = (op == OP_RET) ? CAW'(ctop - CTW'(1)) : CAW'(lidx);
  assign cs_rb = CAW'(ctop - CTW'(2));
  assign dm_raddr = MAW'(args);

  // divider
  logic         div_start, div_done;
  logic [W-1:0] div_q;
  smx_div #(.W(W)) u_div (.clk, .rst, .start(div_start), .dividend(ds_qb),
    .divisor(ds_qa), .done(div_done), .quotient(div_q));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE: if (q_valid) state_next = EX_RD;
      EX_RD:   state_next = EX_WAIT;
      EX_WAIT: state_next = (q_class.is_div && dtop >= DTW'(2) && ds_qa != '0)
                            ? EX_DIV : EX_DONE;
      EX_DIV:  if (div_done) state_next = EX_DONE;
      EX_DONE: if (!out_valid || out_ready) state_next = EX_IDLE;
      default: state_next = EX_IDLE;
    endcase
  end

  assign div_start = (state == EX_WAIT) && (state_next == EX_DIV);

  // execution of the item once operands are read
  logic [ERR_W-1:0] err;
  logic [W-1:0]     a, b, r, top;
  logic [PAW-1:0]   ipn, ip1;
  logic [DTW-1:0]   dtop_n;
  logic [CTW-1:0]   ctop_n;
  logic [CAW-1:0]   fb_n;
  logic             pv, hl;
  logic             w_ds;
  logic [DAW-1:0]   w_ds_a;
  logic [W-1:0]     w_ds_d;
  logic             w_cs;
  logic             ds_full, ds_empty, ds_two;
  logic             nz, taken;

  assign b = ds_qa;
  assign a = ds_qb;
  assign top = ds_qa;
  assign ip1 = (ip == PAW'(PROGRAM_DEPTH - 1)) ? '0 : ip + PAW'(1);
  assign ds_full  = dtop >= DTW'(DATA_STACK_DEPTH);
  assign ds_empty = dtop == '0;
  assign ds_two   = dtop >= DTW'(2);
  assign nz = top != '0;
  assign taken = (op == OP_JIT) ? nz : !nz;

  always_comb begin
    err = ERR_NONE;
    r = '0;
    ipn = ip1;
    dtop_n = dtop;
    ctop_n = ctop;
    fb_n = fb_eff;
    pv = 1'b0;
    hl = 1'b0;
    w_ds = 1'b0;
    w_ds_a = DAW'(dtop);
    w_ds_d = W'(q_argument);
    w_cs = 1'b0;
    unique case (op) inside
      OP_PUSH: if (ds_full) err = ERR_OVER; else begin
        w_ds = 1'b1; dtop_n = dtop + DTW'(1);
      end
      OP_POP: if (ds_empty) err = ERR_UNDER; else dtop_n = dtop - DTW'(1);
      OP_DUP: if (ds_empty) err = ERR_UNDER; else if (ds_full) err = ERR_OVER; else begin
        w_ds = 1'b1; w_ds_d = top; dtop_n = dtop + DTW'(1);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
        case (op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = W'(a * b);
          OP_DIV: r = div_q;
          OP_EQ:  r = W'(a == b);
          OP_GT:  r = W'($signed(a) > $signed(b));
          OP_GE:  r = W'($signed(a) >= $signed(b));
          OP_LT:  r = W'($signed(a) < $signed(b));
          OP_LE:  r = W'($signed(a) <= $signed(b));
          default: r = W'(a != b);
        endcase
        if (!ds_two) err = ERR_UNDER;
        else if (op == OP_DIV && b == '0) err = ERR_DIVZERO;
        else begin
          w_ds = 1'b1; w_ds_a = DAW'(dtop - DTW'(2)); w_ds_d = r;
          dtop_n = dtop - DTW'(1);
        end
      end
      OP_JMP: if (tgt_bad) err = ERR_ADDR; else ipn = PAW'(args);
      OP_JIT, OP_JIF: if (ds_empty) err = ERR_UNDER;
        else if (taken && tgt_bad) err = ERR_ADDR;
        else begin
          dtop_n = dtop - DTW'(1);
          if (taken) ipn = PAW'(args);
        end
      OP_CALL: if (tgt_bad) err = ERR_ADDR;
        else if (ctop + CTW'(2) > CTW'(CALL_STACK_DEPTH) || ctop > CTW'(CALL_STACK_DEPTH - 2))
          err = ERR_CALL;
        else begin
          w_cs = 1'b1; fb_n = CAW'(ctop); ctop_n = ctop + CTW'(2); ipn = PAW'(args);
        end
      OP_RET: if (ctop < CTW'(2)) err = ERR_CALL; else begin
        ctop_n = ctop - CTW'(2);
        fb_n = CAW'(cs_qa);
        ipn = (PAW'(cs_qb) == PAW'(PROGRAM_DEPTH - 1)) ? '0 : PAW'(cs_qb) + PAW'(1);
      end
      OP_STL: if (loc_bad) err = ERR_ADDR; else if (ds_empty) err = ERR_UNDER; else begin
        w_cs = 1'b1; dtop_n = dtop - DTW'(1);
      end
      OP_RCE: if (loc_bad) err = ERR_ADDR; else if (ds_full) err = ERR_OVER; else begin
        w_ds = 1'b1; w_ds_d = cs_qa; dtop_n = dtop + DTW'(1);
      end
      OP_STO: if (mem_bad) err = ERR_ADDR; else if (ds_empty) err = ERR_UNDER;
        else dtop_n = dtop - DTW'(1);
      OP_RCL: if (mem_bad) err = ERR_ADDR; else if (ds_full) err = ERR_OVER; else begin
        w_ds = 1'b1; w_ds_d = dm_q; dtop_n = dtop + DTW'(1);
      end
      OP_END: begin hl = 1'b1; ipn = ip; end
      OP_PRN: if (ds_empty) err = ERR_UNDER; else begin
        pv = 1'b1; dtop_n = dtop - DTW'(1);
      end
      OP_FRE, OP_ALC: if (alc_bad) err = ERR_CALL; else ctop_n = CTW'(alc_t);
      default: ;
    endcase
    if (err != ERR_NONE) begin
      ipn = ip; dtop_n = dtop; ctop_n = ctop; fb_n = fb_eff;
      pv = 1'b0; hl = 1'b0; w_ds = 1'b0; w_cs = 1'b0;
    end
  end

  logic commit;
  assign commit = (state == EX_DONE) && (!out_valid || out_ready);
  assign q_take = commit;

  // memory writes at commit; CALL writes two call-stack words, the second through the cs_we2 register
  assign ds_we    = commit && w_ds;
  assign ds_waddr = w_ds_a;
  assign ds_wdata = w_ds_d;
  assign dm_we    = commit && err == ERR_NONE && op == OP_STO;
  assign dm_waddr = MAW'(args);
  assign dm_wdata = top;

  always_comb begin
    cs_we = cs_we2;
    cs_waddr = cs_waddr2;
    cs_wdata = cs_wdata2;
    if (commit && w_cs) begin
      cs_we = 1'b1;
      if (op == OP_CALL) begin
        cs_waddr = CAW'(ctop);
        cs_wdata = W'(ip);
      end else begin
        cs_waddr = CAW'(lidx);
        cs_wdata = top;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
      ip <= '0; dtop <= '0; ctop <= '0; fb <= '0;
      out_valid <= 1'b0;
      cs_we2 <= 1'b0;
    end else begin
      state <= state_next;
      cs_we2 <= commit && w_cs && op == OP_CALL;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (commit) begin
        out_valid <= 1'b1;
        ip <= ipn; dtop <= dtop_n; ctop <= ctop_n; fb <= fb_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    cs_waddr2 <= CAW'(ctop + CTW'(1));
    cs_wdata2 <= W'(fb_eff);
    if (commit) begin
      next_ip     <= IP_W'(ipn);
      print_valid <= pv;
      print_value <= pv ? PRINT_W'(signed'(top)) : '0;
      halted      <= hl;
      error_code  <= err;
    end
  end

`ifndef SYNTHESIS
  a_dtop_range: assert property (@(posedge clk) disable iff (rst)
    dtop <= DTW'(DATA_STACK_DEPTH)) else $error("data top out of range");
  a_ctop_range: assert property (@(posedge clk) disable iff (rst)
    ctop <= CTW'(CALL_STACK_DEPTH)) else $error("call top out of range");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid) else $error("commit without result");
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    commit && err != ERR_NONE |=> $stable(dtop) && $stable(ctop))
    else $error("fault changed stack");
`endif
endmodule

// ===== hw/rtl/stack_machine_execute_core.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | new_run, opcode, argument
// out     | out_valid / out_ready| next_ip, print_valid, print_value, halted, error_code
// Each item passes through the queue, memory read, settle and commit steps of the
// execute unit; DIV also waits in EX_DIV for the bit-serial divider.
// Reset clears pointers, frame base and the queue; stack and memory contents are
// left as they were. The queue takes the next item while a result waits.
module stack_machine_execute_core import smx_pkg::*; #(
  parameter int WORD_WIDTH       = WORD_WIDTH_DEF,
  parameter int DATA_STACK_DEPTH = DATA_STACK_DEPTH_DEF,
  parameter int CALL_STACK_DEPTH = CALL_STACK_DEPTH_DEF,
  parameter int MEMORY_DEPTH     = MEMORY_DEPTH_DEF,
  parameter int PROGRAM_DEPTH    = PROGRAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                new_run,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [ARG_W-1:0]    argument,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IP_W-1:0]     next_ip,
  output logic                print_valid,
  output logic [PRINT_W-1:0]  print_value,
  output logic                halted,
  output logic [ERR_W-1:0]    error_code
);
  logic                q_valid, q_take, q_new_run;
  logic [OPCODE_W-1:0] q_opcode;
  logic [ARG_W-1:0]    q_argument;
  op_class_t           q_class;

  smx_front u_front (.clk, .rst, .valid(in_valid), .ready(in_ready), .new_run,
    .opcode, .argument, .q_valid, .q_take, .q_new_run, .q_opcode, .q_argument,
    .q_class);

  smx_exec #(.WORD_WIDTH(WORD_WIDTH), .DATA_STACK_DEPTH(DATA_STACK_DEPTH),
    .CALL_STACK_DEPTH(CALL_STACK_DEPTH), .MEMORY_DEPTH(MEMORY_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH)) u_exec (.clk, .rst, .q_valid, .q_take,
    .q_new_run, .q_opcode, .q_argument, .q_class, .out_valid, .out_ready,
    .next_ip, .print_valid, .print_value, .halted, .error_code);
endmodule

// ===== bench/stack_machine_execute_core_test.sv =====
import smx_pkg::*;

module stack_machine_execute_core_test;

  localparam int DSTK_DEPTH = 256;
  localparam int CSTK_DEPTH = 256;
  localparam int MEM_DEPTH  = 256;
  localparam int PROG_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [IP_W-1:0]    ip;
    logic               pv;
    logic [PRINT_W-1:0] pval;
    logic               halt;
    logic [ERR_W-1:0]   err;
  } vm_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic new_run;
  logic [OPCODE_W-1:0] opcode;
  logic [ARG_W-1:0] argument;
  logic out_valid;
  logic out_ready;
  logic [IP_W-1:0] next_ip;
  logic print_valid;
  logic [PRINT_W-1:0] print_value;
  logic halted;
  logic [ERR_W-1:0] error_code;

  stack_machine_execute_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .new_run(new_run), .opcode(opcode), .argument(argument),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_ip(next_ip), .print_valid(print_valid), .print_value(print_value),
    .halted(halted), .error_code(error_code)
  );

  // machine state as the predictor sees it
  int vm_ip, dtop, ctop, fbase;
  logic [31:0] dstk [DSTK_DEPTH];
  logic [31:0] cstk [CSTK_DEPTH];
  logic [31:0] dmem [MEM_DEPTH];
  bit cstk_written [CSTK_DEPTH];
  bit dmem_written [MEM_DEPTH];

  vm_result_t pending_results[$];
  int fails, items_sent, results_seen, prints_seen, halts_seen, faults_seen;
  int cycles;
  int burst_left;
  int ready_mode, ready_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: switches between four random ready modes, one of them never stalls
  always @(posedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt % 64 == 63) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (ready_cnt % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got, exp_v);
    fails++;
  endtask

  always @(posedge clk) begin
    vm_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected item, next_ip", 32'(next_ip), 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (next_ip !== e.ip) report("next_ip", next_ip, e.ip);
        if (print_valid !== e.pv) report("print_valid", print_valid, e.pv);
        if (print_value !== e.pval) report("print_value", print_value, e.pval);
        if (halted !== e.halt) report("halted", halted, e.halt);
        if (error_code !== e.err) report("error_code", error_code, e.err);
      end
      results_seen++;
    end
  end

  function automatic vm_result_t execute_insn(input bit nr, input logic [4:0] op,
                                              input logic [31:0] arg);
    vm_result_t res;
    longint sa, idx, nt;
    int nxt;
    logic [31:0] a, b, r;
    bit taken, tbad;
    logic [ERR_W-1:0] err;
    sa = longint'($signed(arg));
    nxt = (vm_ip + 1) % PROG_DEPTH;
    err = ERR_NONE;
    tbad = (sa < 0) || (sa >= PROG_DEPTH);
    res.pv = 1'b0;
    res.pval = '0;
    res.halt = 1'b0;
    if (nr) fbase = 0;
    case (op)
      OP_PUSH: begin
        if (dtop >= DSTK_DEPTH) err = ERR_OVER;
        else begin dstk[dtop] = arg; dtop++; end
      end
      OP_POP: begin
        if (dtop == 0) err = ERR_UNDER;
        else dtop--;
      end
      OP_DUP: begin
        if (dtop == 0) err = ERR_UNDER;
        else if (dtop >= DSTK_DEPTH) err = ERR_OVER;
        else begin dstk[dtop] = dstk[dtop-1]; dtop++; end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
        if (dtop < 2) err = ERR_UNDER;
        else begin
          b = dstk[dtop-1];
          a = dstk[dtop-2];
          r = '0;
          case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
              if (b == 0) err = ERR_DIVZERO;
              else if (b == 32'hFFFF_FFFF) r = 32'd0 - a;  // wraps for most negative
              else r = $signed(a) / $signed(b);
            end
            OP_EQ: r = {31'd0, a == b};
            OP_GT: r = {31'd0, $signed(a) > $signed(b)};
            OP_GE: r = {31'd0, $signed(a) >= $signed(b)};
            OP_LT: r = {31'd0, $signed(a) < $signed(b)};
            OP_LE: r = {31'd0, $signed(a) <= $signed(b)};
            default: r = {31'd0, a != b};
          endcase
          if (err == ERR_NONE) begin dstk[dtop-2] = r; dtop--; end
        end
      end
      OP_JMP: begin
        if (tbad) err = ERR_ADDR;
        else nxt = int'(sa);
      end
      OP_JIT, OP_JIF: begin
        if (dtop == 0) err = ERR_UNDER;
        else begin
          taken = (op == OP_JIT) ? (dstk[dtop-1] != 0) : (dstk[dtop-1] == 0);
          if (taken && tbad) err = ERR_ADDR;
          else begin
            dtop--;
            if (taken) nxt = int'(sa);
          end
        end
      end
      OP_CALL: begin
        if (tbad) err = ERR_ADDR;
        else if (ctop + 2 > CSTK_DEPTH) err = ERR_CALL;
        else begin
          cstk[ctop] = vm_ip;
          cstk[ctop+1] = fbase;
          cstk_written[ctop] = 1'b1;
          cstk_written[ctop+1] = 1'b1;
          fbase = ctop;
          ctop += 2;
          nxt = int'(sa);
        end
      end
      OP_RET: begin
        if (ctop < 2) err = ERR_CALL;
        else begin
          fbase = cstk[ctop-1] % CSTK_DEPTH;
          nxt = (cstk[ctop-2] % PROG_DEPTH + 1) % PROG_DEPTH;
          ctop -= 2;
        end
      end
      OP_STL, OP_RCE: begin
        idx = longint'(fbase) + sa + 1;
        if (idx < 0 || idx >= CSTK_DEPTH) err = ERR_ADDR;
        else if (op == OP_STL) begin
          if (dtop == 0) err = ERR_UNDER;
          else begin
            dtop--;
            cstk[idx] = dstk[dtop];
            cstk_written[idx] = 1'b1;
          end
        end else begin
          if (dtop >= DSTK_DEPTH) err = ERR_OVER;
          else begin dstk[dtop] = cstk[idx]; dtop++; end
        end
      end
      OP_STO, OP_RCL: begin
        if (sa < 0 || sa >= MEM_DEPTH) err = ERR_ADDR;
        else if (op == OP_STO) begin
          if (dtop == 0) err = ERR_UNDER;
          else begin
            dtop--;
            dmem[sa] = dstk[dtop];
            dmem_written[sa] = 1'b1;
          end
        end else begin
          if (dtop >= DSTK_DEPTH) err = ERR_OVER;
          else begin dstk[dtop] = dmem[sa]; dtop++; end
        end
      end
      OP_END: begin
        res.halt = 1'b1;
        nxt = vm_ip;
      end
      OP_PRN: begin
        if (dtop == 0) err = ERR_UNDER;
        else begin
          dtop--;
          res.pv = 1'b1;
          res.pval = dstk[dtop];
        end
      end
      OP_FRE, OP_ALC: begin
        nt = (op == OP_ALC) ? longint'(ctop) + sa : longint'(ctop) - sa;
        if (nt < 0 || nt > CSTK_DEPTH) err = ERR_CALL;
        else ctop = int'(nt);
      end
      default: ;
    endcase
    if (err != ERR_NONE) begin
      nxt = vm_ip;
      res.pv = 1'b0;
      res.pval = '0;
      res.halt = 1'b0;
    end
    vm_ip = nxt;
    res.ip = nxt[IP_W-1:0];
    res.err = err;
    return res;
  endfunction

  // true when the instruction would fetch a call-stack or memory word never written
  function automatic bit hits_unwritten(input bit nr, input logic [4:0] op,
                                        input logic [31:0] arg);
    longint sa, idx;
    sa = longint'($signed(arg));
    case (op)
      OP_RET: return ctop >= 2 && (!cstk_written[ctop-1] || !cstk_written[ctop-2]);
      OP_RCE: begin
        idx = longint'(nr ? 0 : fbase) + sa + 1;
        return idx >= 0 && idx < CSTK_DEPTH && dtop < DSTK_DEPTH && !cstk_written[idx];
      end
      OP_RCL: return sa >= 0 && sa < MEM_DEPTH && dtop < DSTK_DEPTH && !dmem_written[sa];
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(input bit nr, input logic [4:0] op, input logic [31:0] arg);
    logic [4:0] use_op;
    use_op = hits_unwritten(nr, op, arg) ? OP_PUSH : op;
    in_valid <= 1'b1;
    new_run <= nr;
    opcode <= use_op;
    argument <= arg;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_insn(nr, use_op, arg));
    if (pending_results[$].pv) prints_seen++;
    if (pending_results[$].halt) halts_seen++;
    if (pending_results[$].err != ERR_NONE) faults_seen++;
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  task automatic test_arithmetic;
    logic [4:0] cmp;
    send_item(1'b1, OP_POP, 32'd0);
    send_item(1'b0, OP_PUSH, 32'h7FFF_FFFF);
    send_item(1'b0, OP_PUSH, 32'h8000_0000);
    send_item(1'b0, OP_ADD, 32'd0);
    send_item(1'b0, OP_PUSH, 32'h8000_0000);
    send_item(1'b0, OP_PUSH, 32'hFFFF_FFFF);
    send_item(1'b0, OP_DIV, 32'd0);
    send_item(1'b0, OP_PUSH, 32'd0);
    send_item(1'b0, OP_DIV, 32'd0);
    send_item(1'b0, OP_POP, 32'd0);
    send_item(1'b0, OP_PUSH, 32'd7);
    send_item(1'b0, OP_SUB, 32'd0);
    send_item(1'b0, OP_PUSH, -32'sd3);
    send_item(1'b0, OP_MUL, 32'd0);
    send_item(1'b0, OP_PUSH, -32'sd7);
    send_item(1'b0, OP_PUSH, 32'd2);
    send_item(1'b0, OP_DIV, 32'd0);
    send_item(1'b0, OP_DUP, 32'd0);
    for (cmp = OP_EQ; cmp <= OP_NE; cmp++) begin
      send_item(1'b0, OP_PUSH, 32'd5);
      send_item(1'b0, OP_PUSH, -32'sd5);
      send_item(1'b0, cmp, 32'd0);
      send_item(1'b0, OP_PRN, 32'd0);
    end
  endtask

  task automatic test_control;
    send_item(1'b0, OP_PUSH, 32'hDEAD_BEEF);
    send_item(1'b0, OP_STO, 32'd0);
    send_item(1'b0, OP_RCL, 32'd0);
    send_item(1'b0, OP_STO, 32'd255);
    send_item(1'b0, OP_STO, 32'd256);
    send_item(1'b0, OP_RCL, 32'hFFFF_FFFF);
    send_item(1'b0, OP_JMP, 32'd1023);
    send_item(1'b0, OP_JMP, 32'd1024);
    send_item(1'b0, OP_JMP, 32'h8000_0000);
    send_item(1'b0, OP_PUSH, 32'd1);
    send_item(1'b0, OP_JIT, 32'd5);
    send_item(1'b0, OP_PUSH, 32'd0);
    send_item(1'b0, OP_JIF, 32'd2000);
    send_item(1'b0, OP_JIF, 32'd3);
    send_item(1'b0, OP_PUSH, 32'd0);
    send_item(1'b0, OP_JIT, 32'd2000);
    send_item(1'b0, OP_CALL, 32'd100);
    send_item(1'b0, OP_PUSH, 32'd9);
    send_item(1'b0, OP_STL, 32'd2);
    send_item(1'b0, OP_RCE, 32'd2);
    send_item(1'b0, OP_RCE, 32'hFFFF_FFFE);
    send_item(1'b0, OP_STL, 32'd300);
    send_item(1'b0, OP_RET, 32'd0);
    send_item(1'b0, OP_RET, 32'd0);
    send_item(1'b0, OP_ALC, 32'd3);
    send_item(1'b0, OP_FRE, 32'd3);
    send_item(1'b0, OP_FRE, 32'd1);
    send_item(1'b0, OP_PRN, 32'd0);
    send_item(1'b0, OP_END, 32'd0);
    send_item(1'b0, 5'd26, 32'd0);
    send_item(1'b1, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_stack_limits;
    while (dtop < DSTK_DEPTH) send_item(1'b0, OP_PUSH, $urandom);
    send_item(1'b0, OP_PUSH, 32'd1);
    send_item(1'b0, OP_DUP, 32'd0);
    send_item(1'b0, OP_RCL, 32'd0);
    send_item(1'b0, OP_RCE, 32'd0);
    while (dtop > 0) send_item(1'b0, OP_PRN, 32'd0);
    send_item(1'b0, OP_PRN, 32'd0);
    send_item(1'b0, OP_ALC, 32'd256 - ctop);
    send_item(1'b0, OP_CALL, 32'd5);
    send_item(1'b0, OP_ALC, 32'd1);
    send_item(1'b0, OP_FRE, 32'd256);
    send_item(1'b0, OP_FRE, 32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pick_target();
    return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, PROG_DEPTH - 1);
  endfunction

  task automatic test_random_programs(input int n);
    int k, sel;
    logic [4:0] op;
    logic [31:0] arg;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      arg = 32'd0;
      if (sel < 16) begin
        op = OP_PUSH;
        arg = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : $urandom;
      end else if (sel < 20) op = OP_POP;
      else if (sel < 24) op = OP_DUP;
      else if (sel < 40) begin
        case ($urandom_range(0, 9))
          0: op = OP_ADD;  1: op = OP_SUB;  2: op = OP_MUL;  3: op = OP_DIV;
          4: op = OP_EQ;   5: op = OP_GT;   6: op = OP_GE;   7: op = OP_LT;
          8: op = OP_LE;   default: op = OP_NE;
        endcase
      end else if (sel < 47) begin
        op = ($urandom_range(0, 2) == 0) ? OP_JMP : (($urandom_range(0, 1) != 0) ? OP_JIT : OP_JIF);
        arg = pick_target();
      end else if (sel < 53) begin
        op = OP_CALL;
        arg = pick_target();
      end else if (sel < 59) op = OP_RET;
      else if (sel < 67) begin
        op = ($urandom_range(0, 1) != 0) ? OP_STL : OP_RCE;
        arg = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 7) - 2;
      end else if (sel < 77) begin
        op = ($urandom_range(0, 1) != 0) ? OP_STO : OP_RCL;
        arg = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 15);
      end else if (sel < 79) op = OP_END;
      else if (sel < 88) op = OP_PRN;
      else if (sel < 93) begin
        op = ($urandom_range(0, 1) != 0) ? OP_FRE : OP_ALC;
        arg = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
      end else if (sel < 96) begin
        op = 5'($urandom_range(26, 31));
        arg = $urandom;
      end else begin
        op = OP_PUSH;
        arg = $urandom;
      end
      send_item($urandom_range(0, 19) == 0, op, arg);
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    new_run = 1'b0;
    opcode = OP_PUSH;
    argument = '0;
    out_ready = 1'b0;
    cycles = 0;
    ready_mode = 0;
    ready_cnt = 0;
    burst_left = 5;
    vm_ip = 0; dtop = 0; ctop = 0; fbase = 0;
    for (i = 0; i < CSTK_DEPTH; i++) cstk_written[i] = 1'b0;
    for (i = 0; i < MEM_DEPTH; i++) dmem_written[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_arithmetic();
    test_control();
    test_stack_limits();
    test_random_programs(650);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d instructions executed, %0d results checked", items_sent, results_seen);
    $display("%0d prints, %0d halts, %0d faulting instructions", prints_seen, halts_seen,
             faults_seen);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/smx_pkg.sv
hw/rtl/smx_ram.sv
hw/rtl/smx_div.sv
hw/rtl/smx_front.sv
hw/rtl/smx_exec.sv
hw/rtl/stack_machine_execute_core.sv
bench/stack_machine_execute_core_test.sv
